FILE: design/btf_pkg.sv
// Package for the triangle fill block: widths, constants and small helpers.
// No dependencies.
`default_nettype none
package btf_pkg;
  localparam int COORD_BITS = 12;
  localparam int AREA_BITS = 2 * COORD_BITS + 2;
  localparam int MAG_BITS = 2 * COORD_BITS + 1;
  localparam int NUM_BITS = MAG_BITS + 10;
  localparam int QDEPTH = 4;
  localparam int QPTR = $clog2(QDEPTH);

  typedef struct packed {
    logic [11:0] px;
    logic [11:0] py;
    logic        last;
  } pix_t;

  typedef logic signed [AREA_BITS-1:0] area_t;

  // Take the magnitude of a signed area.
  function automatic logic [MAG_BITS-1:0] mag_f(area_t v);
    area_t n;
    n = v[AREA_BITS-1] ? -v : v;
    return n[MAG_BITS-1:0];
  endfunction
endpackage
`default_nettype wire

FILE: design/btf_front.sv
// Front part: vertex store, bounding box and scan counter.
// Depends on btf_pkg.
`default_nettype none
module btf_front import btf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc,
  input  wire logic        action,
  input  wire logic [1:0]  vidx,
  input  wire logic [11:0] vx,
  input  wire logic [11:0] vy,
  input  wire logic [23:0] vcol,
  output logic             pix_vld,
  output pix_t             pix,
  output logic [COORD_BITS-1:0] xs [3],
  output logic [COORD_BITS-1:0] ys [3],
  output logic [23:0]      cols [3]
);
  logic [COORD_BITS-1:0] sx_r, sy_r, sx_nxt, sy_nxt;
  logic [COORD_BITS-1:0] nx [3];
  logic [COORD_BITS-1:0] ny [3];
  logic [COORD_BITS-1:0] minx, maxx, miny, maxy, lminx, lminy;

  function automatic logic [COORD_BITS-1:0] mn(logic [COORD_BITS-1:0] a, b, c);
    logic [COORD_BITS-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction
  function automatic logic [COORD_BITS-1:0] mx(logic [COORD_BITS-1:0] a, b, c);
    logic [COORD_BITS-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  // Box of the stored and of the updated vertices.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nx[i] = (vidx == 2'(i)) ? vx[COORD_BITS-1:0] : xs[i];
      ny[i] = (vidx == 2'(i)) ? vy[COORD_BITS-1:0] : ys[i];
    end
    minx = mn(xs[0], xs[1], xs[2]);
    maxx = mx(xs[0], xs[1], xs[2]);
    miny = mn(ys[0], ys[1], ys[2]);
    maxy = mx(ys[0], ys[1], ys[2]);
    lminx = mn(nx[0], nx[1], nx[2]);
    lminy = mn(ny[0], ny[1], ny[2]);
  end

  // Advance the scan on a step, restart it on a load of vertex 0 to 2.
  always_comb begin
    sx_nxt = sx_r;
    sy_nxt = sy_r;
    if (acc && !action && vidx != 2'd3) begin
      sx_nxt = lminx;
      sy_nxt = lminy;
    end else if (acc && action) begin
      if (sy_r < maxy) sy_nxt = sy_r + 1'b1;
      else begin
        sy_nxt = miny;
        sx_nxt = (sx_r < maxx) ? sx_r + 1'b1 : minx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0;
      sy_r <= '0;
      for (int i = 0; i < 3; i++) begin
        xs[i] <= '0;
        ys[i] <= '0;
        cols[i] <= '0;
      end
    end else begin
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
      if (acc && !action && vidx != 2'd3) begin
        xs[vidx] <= vx[COORD_BITS-1:0];
        ys[vidx] <= vy[COORD_BITS-1:0];
        cols[vidx] <= vcol;
      end
    end
  end

  assign pix_vld = acc && action;
  assign pix.px = 12'(sx_r);
  assign pix.py = 12'(sy_r);
  assign pix.last = (sx_r >= maxx) && (sy_r >= maxy);
endmodule
`default_nettype wire

FILE: design/btf_div.sv
// Iterative restoring divider: one quotient bit per cycle.
// Depends on btf_pkg.
`default_nettype none
module btf_div import btf_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [NUM_BITS-1:0] num,
  input  wire logic [MAG_BITS-1:0] den,
  output logic                     busy,
  output logic [NUM_BITS-1:0]      quo
);
  localparam int CB = $clog2(NUM_BITS + 1);
  logic [CB-1:0] cnt_r;
  logic [MAG_BITS:0] rem_r, trial;
  logic [MAG_BITS-1:0] den_r;

  assign busy = cnt_r != '0;
  assign trial = {rem_r[MAG_BITS-1:0], quo[NUM_BITS-1]};

  // Shift in one numerator bit and subtract when it fits.
  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (start) begin
      cnt_r <= CB'(NUM_BITS);
      quo <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
      if (trial >= {1'b0, den_r}) begin
        rem_r <= trial - {1'b0, den_r};
        quo <= {quo[NUM_BITS-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        quo <= {quo[NUM_BITS-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/btf_back.sv
// Back part: edge functions, coverage and color division for one pixel.
// Depends on btf_pkg and btf_div.
`default_nettype none
module btf_back import btf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_vld,
  output logic             in_rdy,
  input  wire pix_t        pix,
  input  wire logic [COORD_BITS-1:0] xs [3],
  input  wire logic [COORD_BITS-1:0] ys [3],
  input  wire logic [23:0] cols [3],
  output logic             out_vld,
  input  wire logic        out_rdy,
  output pix_t             opix,
  output logic             ocov,
  output logic [23:0]      ocol
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_EDGE = 5'b00010, S_MUL = 5'b00100,
    S_DIV = 5'b01000, S_OUT = 5'b10000
  } st_t;
  st_t st_r;
  logic [1:0] ch_r, mi_r;
  area_t area_r, w_r [3];
  logic [NUM_BITS-1:0] acc_r;
  logic cov;
  logic dstart, dbusy;
  logic [NUM_BITS-1:0] dq;
  logic [7:0] csel;
  logic [MAG_BITS+7:0] prod;

  function automatic area_t edg(logic [COORD_BITS-1:0] ax, ay, bx, by, cx, cy);
    area_t a, b, c, d;
    a = area_t'(bx) - area_t'(ax);
    b = area_t'(cy) - area_t'(ay);
    c = area_t'(cx) - area_t'(ax);
    d = area_t'(by) - area_t'(ay);
    return a * b - c * d;
  endfunction

  assign in_rdy = st_r == S_IDLE;
  assign out_vld = st_r == S_OUT;
  always_comb begin
    if (area_r > 0) cov = !w_r[0][AREA_BITS-1] && !w_r[1][AREA_BITS-1] &&
                         !w_r[2][AREA_BITS-1];
    else if (area_r < 0) cov = (w_r[0] <= 0) && (w_r[1] <= 0) && (w_r[2] <= 0);
    else cov = 1'b0;
  end
  always_comb begin
    case (ch_r)
      2'd0: csel = cols[mi_r][23:16];
      2'd1: csel = cols[mi_r][15:8];
      default: csel = cols[mi_r][7:0];
    endcase
  end
  assign prod = mag_f(w_r[mi_r]) * csel;
  assign dstart = (st_r == S_MUL) && (mi_r == 2'd3);

  btf_div u_div (.clk, .rst_n, .start(dstart), .num(acc_r), .den(mag_f(area_r)),
                 .busy(dbusy), .quo(dq));

  // Sequence one pixel: edges, then for a covered pixel three products and a divide per channel.
  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else begin
      case (st_r)
        S_IDLE: if (in_vld) begin
          opix <= pix;
          area_r <= edg(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2]);
          w_r[0] <= edg(pix.px[COORD_BITS-1:0], pix.py[COORD_BITS-1:0],
                        xs[1], ys[1], xs[2], ys[2]);
          w_r[1] <= edg(xs[0], ys[0], pix.px[COORD_BITS-1:0],
                        pix.py[COORD_BITS-1:0], xs[2], ys[2]);
          w_r[2] <= edg(xs[0], ys[0], xs[1], ys[1], pix.px[COORD_BITS-1:0],
                        pix.py[COORD_BITS-1:0]);
          st_r <= S_EDGE;
        end
        S_EDGE: begin
          ocov <= cov;
          ocol <= '0;
          ch_r <= 2'd0;
          mi_r <= 2'd0;
          acc_r <= '0;
          st_r <= cov ? S_MUL : S_OUT;
        end
        S_MUL: begin
          if (mi_r == 2'd3) st_r <= S_DIV;
          else begin
            acc_r <= acc_r + NUM_BITS'(prod);
            mi_r <= mi_r + 1'b1;
          end
        end
        S_DIV: if (!dbusy) begin
          ocol <= {ocol[15:0], (dq > 255) ? 8'hFF : dq[7:0]};
          acc_r <= '0;
          mi_r <= 2'd0;
          if (ch_r == 2'd2) st_r <= S_OUT;
          else begin
            ch_r <= ch_r + 1'b1;
            st_r <= S_MUL;
          end
        end
        S_OUT: if (out_rdy) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_cov: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT && !ocov) |-> ocol == '0) else $error("uncovered color");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT && !out_rdy) |=> st_r == S_OUT) else $error("result lost");
  a_div: assert property (@(posedge clk) disable iff (!rst_n)
    dstart |=> dbusy) else $error("divider idle");
endmodule
`default_nettype wire

FILE: design/btf_queue.sv
// Short pixel queue between front and back parts.
// Depends on btf_pkg.
`default_nettype none
module btf_queue import btf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr,
  input  wire pix_t wd,
  output logic      full,
  output logic      nonempty,
  input  wire logic rd,
  output pix_t      rdat
);
  pix_t mem [QDEPTH];
  logic [QPTR-1:0] wp_r, rp_r;
  logic [QPTR:0] cnt_r;
  assign full = cnt_r == (QPTR+1)'(QDEPTH);
  assign nonempty = cnt_r != '0;
  assign rdat = mem[rp_r];
  // Advance pointers on each word moved.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) begin mem[wp_r] <= wd; wp_r <= wp_r + 1'b1; end
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPTR+1)'(wr) - (QPTR+1)'(rd);
    end
  end
endmodule
`default_nettype wire

FILE: design/barycentric_triangle_fill.sv
// Top level of the bounding-box barycentric triangle fill.
// Depends on btf_pkg, btf_front, btf_queue, btf_back.
//
// Usage: push words on the input (push/full). action=0 loads a vertex
// and yields no result; action=1 scans the next pixel of the bounding box and
// yields one result word on the output (empty/pop).
// A pixel outside the triangle goes from the edge state straight to the
// output; a covered pixel also runs three products and the bit-serial divider
// once per color channel.
// The front part accepts scan words while the 4-entry pixel queue has room,
// so scans run ahead of coloring. A load waits until all queued pixels
// are finished, since the back part reads the vertex store directly.
// Reset (synchronous, rst_n low) clears vertices and scan to zero; the box is
// then the single pixel (0,0). When the receiver stalls, the result holds on
// the output ports and the queue fills, then full rises.
`default_nettype none
module barycentric_triangle_fill import btf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic        in_action,
  input  wire logic [1:0]  in_vertex_index,
  input  wire logic [11:0] in_vertex_x,
  input  wire logic [11:0] in_vertex_y,
  input  wire logic [7:0]  in_vertex_red,
  input  wire logic [7:0]  in_vertex_green,
  input  wire logic [7:0]  in_vertex_blue,
  output logic             empty,
  input  wire logic        pop,
  output logic [11:0]      out_pixel_x,
  output logic [11:0]      out_pixel_y,
  output logic             out_covered,
  output logic [7:0]       out_red_out,
  output logic [7:0]       out_green_out,
  output logic [7:0]       out_blue_out,
  output logic             out_last_pixel
);
  logic qfull, qne, brdy, bvld, acc, pv, busy_back;
  pix_t pw, qd, op;
  logic [COORD_BITS-1:0] xs [3];
  logic [COORD_BITS-1:0] ys [3];
  logic [23:0] cols [3];
  logic [23:0] oc;

  // Hold loads until queued pixels have drained through the back part.
  assign busy_back = qne || !brdy;
  assign full = qfull || (!in_action && busy_back);
  assign acc = push && !full;

  btf_front u_front (.clk, .rst_n, .acc, .action(in_action), .vidx(in_vertex_index),
    .vx(in_vertex_x), .vy(in_vertex_y),
    .vcol({in_vertex_red, in_vertex_green, in_vertex_blue}),
    .pix_vld(pv), .pix(pw), .xs, .ys, .cols);
  btf_queue u_q (.clk, .rst_n, .wr(pv), .wd(pw), .full(qfull), .nonempty(qne),
    .rd(qne && brdy), .rdat(qd));
  btf_back u_back (.clk, .rst_n, .in_vld(qne), .in_rdy(brdy), .pix(qd), .xs, .ys,
    .cols, .out_vld(bvld), .out_rdy(pop), .opix(op), .ocov(out_covered), .ocol(oc));

  assign empty = !bvld;
  assign out_pixel_x = op.px;
  assign out_pixel_y = op.py;
  assign out_last_pixel = op.last;
  assign out_red_out = oc[23:16];
  assign out_green_out = oc[15:8];
  assign out_blue_out = oc[7:0];
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Testbench for barycentric_triangle_fill: directed and random vertex loads and
// pixel steps, with a scoreboard that predicts each pixel word. Depends on btf_pkg.
`default_nettype none
module testbench;
  import btf_pkg::*;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;
  localparam int LIMIT_CYCLES = 2000000;

  typedef struct packed {
    logic        action;
    logic [1:0]  vidx;
    logic [11:0] vx;
    logic [11:0] vy;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
  } in_word_t;

  typedef struct packed {
    logic [11:0] px;
    logic [11:0] py;
    logic        covered;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        last;
  } pixel_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  in_word_t drv = '0;
  logic [11:0] o_px, o_py;
  logic o_cov, o_last;
  logic [7:0] o_r, o_g, o_b;

  in_word_t pending_words[$];
  pixel_word_t expected_pixels[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_send = 1'b0;
  int cycle_count = 0;

  // Predictor state
  logic [11:0] vx_s[3], vy_s[3];
  logic [7:0]  col_s[3][3];
  logic [11:0] sx, sy;

  barycentric_triangle_fill uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_action(drv.action), .in_vertex_index(drv.vidx),
    .in_vertex_x(drv.vx), .in_vertex_y(drv.vy),
    .in_vertex_red(drv.r), .in_vertex_green(drv.g), .in_vertex_blue(drv.b),
    .empty(empty), .pop(pop),
    .out_pixel_x(o_px), .out_pixel_y(o_py), .out_covered(o_cov),
    .out_red_out(o_r), .out_green_out(o_g), .out_blue_out(o_b),
    .out_last_pixel(o_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [11:0] lo3(logic [11:0] a, logic [11:0] b, logic [11:0] c);
    logic [11:0] m;
    m = a < b ? a : b;
    return m < c ? m : c;
  endfunction

  function automatic logic [11:0] hi3(logic [11:0] a, logic [11:0] b, logic [11:0] c);
    logic [11:0] m;
    m = a > b ? a : b;
    return m > c ? m : c;
  endfunction

  function automatic longint cross2(logic [11:0] px, logic [11:0] py,
                                    logic [11:0] qx, logic [11:0] qy,
                                    logic [11:0] rx, logic [11:0] ry);
    return (longint'(qx) - longint'(px)) * (longint'(ry) - longint'(py)) -
           (longint'(rx) - longint'(px)) * (longint'(qy) - longint'(py));
  endfunction

  // Apply one accepted word to the predictor; queue the pixel for a step.
  task automatic rasterize(in_word_t w);
    longint area, wt[3], num, den;
    logic [11:0] mnx, mxx, mny, mxy;
    pixel_word_t p;
    if (w.action == ACT_LOAD) begin
      if (w.vidx > 2) return;
      vx_s[w.vidx] = w.vx;
      vy_s[w.vidx] = w.vy;
      col_s[w.vidx][0] = w.r;
      col_s[w.vidx][1] = w.g;
      col_s[w.vidx][2] = w.b;
      sx = lo3(vx_s[0], vx_s[1], vx_s[2]);
      sy = lo3(vy_s[0], vy_s[1], vy_s[2]);
      return;
    end
    mnx = lo3(vx_s[0], vx_s[1], vx_s[2]);
    mxx = hi3(vx_s[0], vx_s[1], vx_s[2]);
    mny = lo3(vy_s[0], vy_s[1], vy_s[2]);
    mxy = hi3(vy_s[0], vy_s[1], vy_s[2]);
    area = cross2(vx_s[0], vy_s[0], vx_s[1], vy_s[1], vx_s[2], vy_s[2]);
    wt[0] = cross2(sx, sy, vx_s[1], vy_s[1], vx_s[2], vy_s[2]);
    wt[1] = cross2(vx_s[0], vy_s[0], sx, sy, vx_s[2], vy_s[2]);
    wt[2] = cross2(vx_s[0], vy_s[0], vx_s[1], vy_s[1], sx, sy);
    p = '0;
    p.px = sx;
    p.py = sy;
    if (area > 0) p.covered = wt[0] >= 0 && wt[1] >= 0 && wt[2] >= 0;
    else if (area < 0) p.covered = wt[0] <= 0 && wt[1] <= 0 && wt[2] <= 0;
    if (p.covered) begin
      den = area < 0 ? -area : area;
      for (int k = 0; k < 3; k++) begin
        num = 0;
        for (int i = 0; i < 3; i++)
          num += (wt[i] < 0 ? -wt[i] : wt[i]) * longint'(col_s[i][k]);
        num = num / den;
        if (num > 255) num = 255;
        if (k == 0) p.r = num[7:0];
        else if (k == 1) p.g = num[7:0];
        else p.b = num[7:0];
      end
    end
    p.last = (sx >= mxx) && (sy >= mxy);
    if (sy < mxy) begin
      sy = sy + 12'd1;
    end else begin
      sy = mny;
      sx = (sx < mxx) ? sx + 12'd1 : mnx;
    end
    expected_pixels.push_back(p);
  endtask

  // Drive: present the oldest pending word, idle at random, hold while paused; pop at random.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_send && pending_words.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        drv <= pending_words[0];
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
      pop <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // Monitor: predict and drop accepted words, check popped pixels.
  always @(posedge clk) begin
    pixel_word_t e;
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (push && !full) begin
        rasterize(drv);
        pending_words.pop_front();
      end
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel word at x=%0d y=%0d", o_px, o_py);
          errors++;
        end else begin
          e = expected_pixels.pop_front();
          if (o_px !== e.px) begin $error("pixel_x exp %0d got %0d", e.px, o_px); errors++; end
          if (o_py !== e.py) begin $error("pixel_y exp %0d got %0d", e.py, o_py); errors++; end
          if (o_cov !== e.covered) begin
            $error("covered exp %0d got %0d", e.covered, o_cov); errors++;
          end
          if (o_r !== e.r) begin $error("red_out exp %0d got %0d", e.r, o_r); errors++; end
          if (o_g !== e.g) begin $error("green_out exp %0d got %0d", e.g, o_g); errors++; end
          if (o_b !== e.b) begin $error("blue_out exp %0d got %0d", e.b, o_b); errors++; end
          if (o_last !== e.last) begin
            $error("last_pixel exp %0d got %0d", e.last, o_last); errors++;
          end
        end
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    if (cycle_count > LIMIT_CYCLES) begin
      $display("testbench: errors");
      $finish;
    end
  end

  function automatic in_word_t load_word(int idx, int x, int y, int r, int g, int b);
    in_word_t w;
    w.action = ACT_LOAD;
    w.vidx = 2'(idx);
    w.vx = 12'(x); w.vy = 12'(y);
    w.r = 8'(r); w.g = 8'(g); w.b = 8'(b);
    return w;
  endfunction

  function automatic in_word_t step_word();
    in_word_t w;
    w = '0;
    w.action = ACT_STEP;
    w.vidx = 2'($urandom_range(3));
    w.vx = 12'($urandom); w.vy = 12'($urandom);
    w.r = 8'($urandom); w.g = 8'($urandom); w.b = 8'($urandom);
    return w;
  endfunction

  task automatic queue_steps(int n);
    for (int i = 0; i < n; i++) pending_words.push_back(step_word());
  endtask

  // Small random triangle, then a walk of part or all of its box.
  task automatic queue_triangle();
    int bx, by, span;
    span = ($urandom_range(9) == 0) ? 10 : 4;
    bx = $urandom_range(4095 - span);
    by = $urandom_range(4095 - span);
    for (int i = 0; i < 3; i++)
      pending_words.push_back(load_word(i, bx + $urandom_range(span), by + $urandom_range(span),
                                        $urandom, $urandom, $urandom));
    if ($urandom_range(7) == 0)
      pending_words.push_back(load_word(3, $urandom, $urandom, $urandom, $urandom, $urandom));
    queue_steps($urandom_range(4, 30));
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || expected_pixels.size() > 0) @(posedge clk);
  endtask

  task automatic random_phase(int sidle, int ridle, int n);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        pending_words.push_back($urandom_range(1) ? step_word()
          : load_word($urandom_range(3), $urandom, $urandom, $urandom, $urandom, $urandom));
      else queue_triangle();
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < 3; i++) begin
      vx_s[i] = '0; vy_s[i] = '0;
      for (int k = 0; k < 3; k++) col_s[i][k] = '0;
    end
    sx = '0; sy = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset box, extremes, degenerate, wrap, ignored index three.
    queue_steps(2);
    pending_words.push_back(load_word(0, 0, 0, 255, 0, 0));
    pending_words.push_back(load_word(1, 2, 0, 0, 255, 0));
    pending_words.push_back(load_word(2, 0, 2, 0, 0, 255));
    queue_steps(10);
    pending_words.push_back(load_word(3, 4095, 4095, 255, 255, 255));
    pending_words.push_back(load_word(1, 4095, 4095, 255, 255, 255));
    pending_words.push_back(load_word(0, 4094, 4095, 255, 255, 255));
    pending_words.push_back(load_word(2, 4095, 4094, 255, 255, 255));
    queue_steps(5);
    pending_words.push_back(load_word(2, 4093, 4093, 170, 85, 0));
    queue_steps(2);
    wait_drained();

    random_phase(11, 59, 35);
    // Let the block run dry with the sender held off.
    hold_send = 1'b1;
    wait_drained();
    hold_send = 1'b0;
    random_phase(59, 11, 35);
    random_phase(0, 0, 30);

    repeat (200) @(posedge clk);
    if (errors == 0 && expected_pixels.size() == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end
endmodule
`default_nettype wire
